/* sv/pqs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_pkg
// shared constants and types for the pq code scan with top-k list
// ----------------------------------------------------------------------------
package pqs_pkg;
    localparam int MAX_SUBQUANTIZERS = 8;
    localparam int CENTROIDS_PER_SUB = 256;
    localparam int MAX_K             = 16;
    localparam int PAIR_SHIFT        = 32;
    localparam int SUB_W  = $clog2(MAX_SUBQUANTIZERS);
    localparam int CEN_W  = $clog2(CENTROIDS_PER_SUB);
    localparam int BANK_W = (CEN_W < 1) ? 1 : CEN_W;
    localparam int RANK_W = $clog2(MAX_K);
    localparam int KIDX_W = (RANK_W < 1) ? 1 : RANK_W;
    localparam int CNT_W  = $clog2(MAX_K + 1);
    localparam int VAL_W  = 20;
    localparam int SUM_W  = 23;
    localparam int LBL_W  = 64;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_SCAN  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [2:0] CFG_METRIC = 3'd0;
    localparam logic [2:0] CFG_PAIR   = 3'd1;
    localparam logic [2:0] CFG_SUBQ   = 3'd2;
    localparam logic [2:0] CFG_RCOUNT = 3'd3;
    localparam logic [2:0] CFG_LCOUNT = 3'd4;

    // insertion request to the top-k list
    typedef struct packed {
        logic                    valid;
        logic                    metric;
        logic [CNT_W-1:0]        k;
        logic signed [SUM_W-1:0] sum;
        logic [LBL_W-1:0]        label;
    } t_ins;
endpackage

/* sv/pqs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module pqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* sv/pqs_lanes.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_lanes
// one table bank per subquantizer, read side by side, then a registered
// adder tree that merges the lane values into the code's distance sum
// ----------------------------------------------------------------------------
module pqs_lanes import pqs_pkg::*; (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic [10:0]                          i_table_address,
    input  logic signed [VAL_W-1:0]              i_table_value,
    input  logic                                 i_scan,
    input  logic                                 i_flush,
    input  logic [63:0]                          i_code_bytes,
    input  logic [3:0]                           i_subq,
    input  t_ins                                 i_ins,
    output t_ins                                 o_ins
);
    localparam int LVL1 = (MAX_SUBQUANTIZERS + 1) / 2;

    logic [VAL_W-1:0]        w_rd   [MAX_SUBQUANTIZERS];
    logic [MAX_SUBQUANTIZERS-1:0] r_en;
    logic signed [SUM_W-1:0] r_half [LVL1];
    t_ins                    r_s1, r_s2;
    logic [3:0]              w_mcnt;
    logic [SUB_W:0]          w_sub;
    logic [7:0]              w_cen;

    assign w_mcnt = (i_subq > 4'(MAX_SUBQUANTIZERS)) ? 4'(MAX_SUBQUANTIZERS) : i_subq;
    assign w_sub  = (SUB_W + 1)'(i_table_address[10:8]);
    assign w_cen  = i_table_address[7:0];

    for (genvar m = 0; m < MAX_SUBQUANTIZERS; m++) begin : g_lane
        logic [7:0]        w_c;
        logic [BANK_W-1:0] w_ra;
        logic              w_we;
        assign w_c  = i_code_bytes[8*m +: 8];
        assign w_ra = (w_c >= 8'(CENTROIDS_PER_SUB - 1)) ?
                      BANK_W'(CENTROIDS_PER_SUB - 1) : BANK_W'(w_c);
        assign w_we = i_load && ({1'b0, i_table_address[10:8]} == 4'(m))
                      && ({1'b0, w_cen} < 9'(CENTROIDS_PER_SUB));
        pqs_ram #(.WIDTH(VAL_W), .DEPTH(1 << BANK_W)) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (BANK_W'(w_cen)),
            .i_wdata (i_table_value),
            .i_raddr (w_ra),
            .o_rdata (w_rd[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_scan && i_ins.valid;
            // a begin query drops the scan that is still in the pipe
            r_s2.valid <= r_s1.valid && !i_flush;
        end
        r_s1.metric <= i_ins.metric;
        r_s1.k      <= i_ins.k;
        r_s1.label  <= i_ins.label;
        r_s1.sum    <= '0;
        for (int m = 0; m < MAX_SUBQUANTIZERS; m++) begin
            r_en[m] <= 4'(m) < w_mcnt;
        end
        for (int h = 0; h < LVL1; h++) begin
            logic signed [SUM_W-1:0] a, b;
            a = r_en[2*h] ? SUM_W'($signed(w_rd[2*h])) : '0;
            b = '0;
            if (2*h + 1 < MAX_SUBQUANTIZERS) begin
                if (r_en[2*h+1]) b = SUM_W'($signed(w_rd[2*h+1]));
            end
            r_half[h] <= a + b;
        end
        r_s2.metric <= r_s1.metric;
        r_s2.k      <= r_s1.k;
        r_s2.label  <= r_s1.label;
        r_s2.sum    <= '0;
    end

    // final merge of the pair sums
    always_comb begin
        o_ins = r_s2;
        o_ins.sum = '0;
        for (int h = 0; h < LVL1; h++) begin
            o_ins.sum = o_ins.sum + r_half[h];
        end
    end

    unused_w_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid |-> $past(r_s1.valid))
        else $error("lane pipeline lost an item");
    a_p2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_scan && i_ins.valid) |=> r_s1.valid)
        else $error("scan not captured");
    a_p3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && w_sub >= (SUB_W + 1)'(MAX_SUBQUANTIZERS) && (|r_en === 1'bx)))
        else $error("bad load");
endmodule

/* sv/pqs_topk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_topk
// sorted top-k list: every slot compares the new sum at once and shifts
// ----------------------------------------------------------------------------
module pqs_topk import pqs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  t_ins                    i_ins,
    input  logic [KIDX_W-1:0]       i_rd_idx,
    output logic signed [SUM_W-1:0] o_rd_sum,
    output logic [LBL_W-1:0]        o_rd_label,
    output logic [CNT_W-1:0]        o_count
);
    logic signed [SUM_W-1:0] r_sum   [MAX_K];
    logic [LBL_W-1:0]        r_label [MAX_K];
    logic [CNT_W-1:0]        r_count;
    logic [MAX_K-1:0]        w_bet;
    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_pos;
    logic                    w_drop;

    assign w_n = (r_count < i_ins.k) ? r_count : i_ins.k;

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_bet[i] = (CNT_W'(i) < w_n) &&
                       (i_ins.metric ? (i_ins.sum > r_sum[i]) : (i_ins.sum < r_sum[i]));
        end
        w_drop = (w_n == i_ins.k) && !w_bet[KIDX_W'(i_ins.k - CNT_W'(1))];
        // first slot that the new sum beats, or the fill level
        w_pos = w_n;
        for (int i = MAX_K - 1; i >= 0; i--) begin
            if (w_bet[i]) w_pos = CNT_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
            for (int i = 0; i < MAX_K; i++) begin
                r_sum[i]   <= '0;
                r_label[i] <= '1;
            end
        end else if (i_ins.valid && !w_drop) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (CNT_W'(i) < i_ins.k) begin
                    if (CNT_W'(i) == w_pos) begin
                        r_sum[i]   <= i_ins.sum;
                        r_label[i] <= i_ins.label;
                    end else if (CNT_W'(i) > w_pos && CNT_W'(i) <= w_n) begin
                        r_sum[i]   <= r_sum[(i == 0) ? 0 : i-1];
                        r_label[i] <= r_label[(i == 0) ? 0 : i-1];
                    end
                end
            end
            r_count <= (w_n < i_ins.k) ? w_n + CNT_W'(1) : i_ins.k;
        end
    end

    assign o_rd_sum   = r_sum[i_rd_idx];
    assign o_rd_label = r_label[i_rd_idx];
    assign o_count    = r_count;

    a_t1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_K))
        else $error("count overflow");
    a_t2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_count == '0)
        else $error("clear failed");
    a_t3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_clear && !i_ins.valid) |=> $stable(r_count))
        else $error("count moved without insertion");
endmodule

/* sv/pq_code_scan_top_k.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_code_scan_top_k
// product-quantization code scan with a sorted top-k result list
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | i_valid / o_stall     | i_req_type .. i_entry_offset
//  out     | o_valid / i_stall     | o_rank .. o_last
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  load, begin: taken at once; scan: enters at once, registered lane reads
//  and the adder tree's registered pair sums hand the sum to the list; a begin
//  drops scans still in the pipe; a readout stalls the input while the scan
//  pipe drains and then emits k results, one per cycle unless stalled.
//  reset clears the list and registers; table banks are not cleared.
// ----------------------------------------------------------------------------
module pq_code_scan_top_k import pqs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [10:0]             i_table_address,
    input  logic signed [19:0]      i_table_value,
    input  logic [63:0]             i_code_bytes,
    input  logic [62:0]             i_vector_id,
    input  logic [15:0]             i_list_number,
    input  logic [31:0]             i_entry_offset,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [3:0]              o_rank,
    output logic signed [22:0]      o_distance_sum,
    output logic signed [63:0]      o_label,
    output logic                    o_filled,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_READ} t_state;

    t_state            r_state;
    logic              r_metric, r_pair;
    logic [3:0]        r_subq;
    logic [4:0]        r_rcount;
    logic [16:0]       r_lcount;
    logic [1:0]        r_drain;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  w_k, w_n;
    logic              w_acc, w_out_acc;
    t_ins              w_ins, w_lane_out;
    logic signed [SUM_W-1:0] w_rd_sum;
    logic [LBL_W-1:0]  w_rd_label;
    logic [CNT_W-1:0]  w_count;

    assign w_k = (r_rcount == 5'd0) ? CNT_W'(1) :
                 (r_rcount > 5'(MAX_K)) ? CNT_W'(MAX_K) : CNT_W'(r_rcount);
    assign w_n = (w_count < w_k) ? w_count : w_k;
    assign o_stall     = (r_state != ST_RUN);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && !o_stall;
    assign w_out_acc   = o_valid && !i_stall;

    always_comb begin
        w_ins.valid  = {1'b0, i_list_number} < r_lcount;
        w_ins.metric = r_metric;
        w_ins.k      = w_k;
        w_ins.sum    = '0;
        w_ins.label  = r_pair ? {16'd0, i_list_number, i_entry_offset}
                              : {1'b0, i_vector_id};
    end

    pqs_lanes u_lanes (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_load(w_acc && i_req_type == REQ_LOAD),
        .i_table_address(i_table_address), .i_table_value(i_table_value),
        .i_scan(w_acc && i_req_type == REQ_SCAN),
        .i_flush(w_acc && i_req_type == REQ_BEGIN),
        .i_code_bytes(i_code_bytes), .i_subq(r_subq),
        .i_ins(w_ins), .o_ins(w_lane_out)
    );

    pqs_topk u_topk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_clear(w_acc && i_req_type == REQ_BEGIN),
        .i_ins(w_lane_out), .i_rd_idx(KIDX_W'(r_idx)),
        .o_rd_sum(w_rd_sum), .o_rd_label(w_rd_label), .o_count(w_count)
    );

    assign o_valid        = (r_state == ST_READ);
    assign o_rank         = 4'(r_idx);
    assign o_filled       = r_idx < w_n;
    assign o_distance_sum = o_filled ? w_rd_sum : '0;
    assign o_label        = o_filled ? w_rd_label : '1;
    assign o_last         = (r_idx + CNT_W'(1)) == w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_metric <= 1'b0;
            r_pair   <= 1'b0;
            r_subq   <= 4'd8;
            r_rcount <= 5'd16;
            r_lcount <= 17'd65536;
            r_drain  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_METRIC: r_metric <= i_cfg_data[0];
                    CFG_PAIR:   r_pair   <= i_cfg_data[0];
                    CFG_SUBQ:   r_subq   <= i_cfg_data[3:0];
                    CFG_RCOUNT: r_rcount <= i_cfg_data[4:0];
                    CFG_LCOUNT: r_lcount <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_RUN: begin
                    if (w_acc && i_req_type == REQ_READ) begin
                        r_state <= ST_DRAIN;
                        r_drain <= 2'd3;
                        r_idx   <= '0;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain - 2'd1;
                    if (r_drain == 2'd1) r_state <= ST_READ;
                end
                ST_READ: begin
                    if (w_out_acc) begin
                        r_idx <= r_idx + CNT_W'(1);
                        if (o_last) r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    a_1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_idx < w_k)
        else $error("readout index past k");
    a_2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last) |=> r_state == ST_RUN)
        else $error("readout did not end");
    a_3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_lane_out.valid)
        else $error("insertion during readout");
endmodule

/* bench/tb_pq_code_scan_top_k.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pq_code_scan_top_k
// randomized check of the pq code scan with top-k readout
// ----------------------------------------------------------------------------
// loads distance tables, streams scan codes in bursts and compares each
// readout item against a local top-k model, across several register settings
// ----------------------------------------------------------------------------
module tb_pq_code_scan_top_k;
    import pqs_pkg::*;

    class topk_board;
        logic signed [19:0] dist_tab [0:2047];
        logic signed [22:0] keep_sum [0:MAX_K-1];
        logic [63:0]        keep_lbl [0:MAX_K-1];
        int                 keep_n;
        bit                 mode_ip, pairs;
        int                 subq, kreg, lcount;
        logic [3:0]         q_rank [$];
        logic signed [22:0] q_sum [$];
        logic [63:0]        q_lbl [$];
        bit                 q_fill [$], q_last [$];
        int                 errors, checked;

        function void clear_list();
            for (int i = 0; i < MAX_K; i++) begin
                keep_sum[i] = 0;
                keep_lbl[i] = '1;
            end
            keep_n = 0;
        endfunction

        function void init();
            clear_list();
            mode_ip = 0; pairs = 0; subq = 8; kreg = 16; lcount = 65536;
            errors = 0; checked = 0;
        endfunction

        function int k_now();
            return (kreg < 1) ? 1 : (kreg > MAX_K) ? MAX_K : kreg;
        endfunction

        function bit ahead(logic signed [22:0] a, logic signed [22:0] b);
            return mode_ip ? (a > b) : (a < b);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_METRIC: mode_ip = v[0];
                CFG_PAIR:   pairs = v[0];
                CFG_SUBQ:   subq = v[3:0];
                CFG_RCOUNT: kreg = v[4:0];
                CFG_LCOUNT: lcount = v[16:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] rq, logic [10:0] ad, logic signed [19:0] tv,
                                logic [63:0] cb, logic [62:0] vid, logic [15:0] ln,
                                logic [31:0] off);
            int k, n, pos, m, i;
            logic signed [22:0] s;
            logic [63:0] lb;
            k = k_now();
            n = (keep_n < k) ? keep_n : k;
            case (rq)
                REQ_BEGIN: clear_list();
                REQ_LOAD: begin
                    dist_tab[ad] = tv;
                end
                REQ_SCAN: begin
                    if (ln < lcount) begin
                        s = 0;
                        m = (subq > MAX_SUBQUANTIZERS) ? MAX_SUBQUANTIZERS : subq;
                        for (i = 0; i < m; i++) s += dist_tab[i*256 + cb[8*i +: 8]];
                        lb = pairs ? {16'd0, ln, off} : {1'b0, vid};
                        if (!(n == k && !ahead(s, keep_sum[k-1]))) begin
                            pos = 0;
                            while (pos < n && !ahead(s, keep_sum[pos])) pos++;
                            for (i = (n < k) ? n : k - 1; i > pos; i--) begin
                                keep_sum[i] = keep_sum[i-1];
                                keep_lbl[i] = keep_lbl[i-1];
                            end
                            keep_sum[pos] = s;
                            keep_lbl[pos] = lb;
                            keep_n = (n < k) ? n + 1 : k;
                        end
                    end
                end
                default: begin
                    for (i = 0; i < k; i++) begin
                        q_rank.push_back(i[3:0]);
                        q_sum.push_back(i < n ? keep_sum[i] : 23'sd0);
                        q_lbl.push_back(i < n ? keep_lbl[i] : '1);
                        q_fill.push_back(i < n);
                        q_last.push_back(i == k - 1);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [3:0] r, logic signed [22:0] s, logic [63:0] l,
                                   logic f, logic la);
            if (q_rank.size() == 0) begin
                $error("result with nothing expected: rank %0d", r);
                errors++;
                return;
            end
            checked++;
            if (r !== q_rank[0]) begin
                $error("rank: expected %0d got %0d", q_rank[0], r); errors++;
            end
            if (s !== q_sum[0]) begin
                $error("distance_sum: expected %0d got %0d", q_sum[0], s); errors++;
            end
            if (l !== q_lbl[0]) begin
                $error("label: expected %h got %h", q_lbl[0], l); errors++;
            end
            if (f !== q_fill[0]) begin
                $error("filled: expected %0d got %0d", q_fill[0], f); errors++;
            end
            if (la !== q_last[0]) begin
                $error("last: expected %0d got %0d", q_last[0], la); errors++;
            end
            void'(q_rank.pop_front()); void'(q_sum.pop_front()); void'(q_lbl.pop_front());
            void'(q_fill.pop_front()); void'(q_last.pop_front());
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0, i_cfg_valid = 0;
    logic [1:0] i_req_type = 0;
    logic [10:0] i_table_address = 0;
    logic signed [19:0] i_table_value = 0;
    logic [63:0] i_code_bytes = 0;
    logic [62:0] i_vector_id = 0;
    logic [15:0] i_list_number = 0;
    logic [31:0] i_entry_offset = 0;
    logic [2:0] i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_stall, o_valid, o_filled, o_last, o_cfg_ready;
    logic [3:0] o_rank;
    logic signed [22:0] o_distance_sum;
    logic signed [63:0] o_label;

    topk_board board = new();
    int stall_mode = 0, n_reads = 0, n_scans = 0;

    pq_code_scan_top_k dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // receiver stall pattern changes character from time to time
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_rank, o_distance_sum, o_label, o_filled, o_last);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // centroid picks limited to the loaded ones: 0..7 and 255
    function automatic logic [7:0] pick_cen(int b);
        return (b >= 8) ? 8'hFF : 8'(b);
    endfunction

    function automatic logic [63:0] rand_code();
        logic [63:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) c[8*i +: 8] = pick_cen($urandom_range(0, 8));
        return c;
    endfunction

    task automatic send_item(logic [1:0] rq, logic [10:0] ad, logic signed [19:0] tv,
                             logic [63:0] cb, logic [62:0] vid, logic [15:0] ln,
                             logic [31:0] off);
        i_valid <= 1; i_req_type <= rq; i_table_address <= ad; i_table_value <= tv;
        i_code_bytes <= cb; i_vector_id <= vid; i_list_number <= ln;
        i_entry_offset <= off;
        do @(posedge i_clk); while (o_stall);
        board.note_item(rq, ad, tv, cb, vid, ln, off);
        if (rq == REQ_SCAN) n_scans++;
        if (rq == REQ_READ) n_reads++;
        // burst gaps
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (board.q_rank.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic send_rand(logic [1:0] rq);
        send_item(rq, 11'($urandom), 20'($urandom), rand64(), 63'(rand64()),
                  16'($urandom), $urandom);
    endtask

    task automatic load_tables();
        for (int s = 0; s < MAX_SUBQUANTIZERS; s++)
            for (int c = 0; c < 9; c++)
                send_item(REQ_LOAD, {3'(s), pick_cen(c)}, 20'($urandom), rand64(),
                          63'(rand64()), 16'($urandom), $urandom);
    endtask

    task automatic scan(logic [15:0] ln);
        send_item(REQ_SCAN, 11'($urandom), 20'($urandom), rand_code(), 63'(rand64()),
                  ln, $urandom);
    endtask

    task automatic read_out();
        send_rand(REQ_READ);
    endtask

    task automatic run_phase(int items, int lc);
        send_rand(REQ_BEGIN);
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(0, 19))
                0: read_out();
                1: send_rand(REQ_BEGIN);
                2: send_rand(REQ_LOAD);
                3: scan(16'($urandom_range(0, 65535)));
                default: scan(16'($urandom_range(0, (lc > 1) ? lc : 1)));
            endcase
        end
        read_out();
        wait_idle();
    endtask

    initial begin
        board.init();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: readout of the empty list, then a table load
        read_out();
        load_tables();
        wait_idle();
        // directed: extremes of the table word and ties
        send_item(REQ_LOAD, 11'd0, 20'sh80000, '0, '0, '0, '0);
        send_item(REQ_LOAD, 11'd255, 20'sh7FFFF, '0, '0, '0, '0);
        send_item(REQ_LOAD, 11'd2047, 20'sh7FFFF, '0, '0, '0, '0);
        send_item(REQ_BEGIN, '0, '0, '0, '0, '0, '0);
        send_item(REQ_SCAN, '0, '0, 64'd0, 63'd0, 16'd0, 32'd0);
        send_item(REQ_SCAN, '0, '0, 64'd0, '1, 16'hFFFF, '1);
        send_item(REQ_SCAN, '0, '0, '1, 63'd5, 16'd3, 32'd9);
        send_item(REQ_SCAN, '0, '0, 64'h00000000000000FF, 63'd7, 16'd1, 32'd1);
        read_out();
        wait_idle();
        write_reg(CFG_METRIC, 1);
        write_reg(CFG_PAIR, 1);
        read_out();
        send_item(REQ_SCAN, '0, '0, '1, '1, 16'hFFFF, '1);
        send_item(REQ_SCAN, '0, '0, '1, 63'd1, 16'd2, 32'd2);
        read_out();
        wait_idle();
        // smaller k mid-query keeps the head of the list
        write_reg(CFG_RCOUNT, 2);
        read_out();
        wait_idle();
        // random phases over a spread of settings
        run_phase(50, 65535);
        write_reg(CFG_METRIC, 0); write_reg(CFG_PAIR, 0);
        write_reg(CFG_SUBQ, 1); write_reg(CFG_RCOUNT, 1); write_reg(CFG_LCOUNT, 1);
        run_phase(40, 1);
        write_reg(CFG_SUBQ, 8); write_reg(CFG_RCOUNT, 16); write_reg(CFG_LCOUNT, 65536);
        run_phase(60, 65535);
        write_reg(CFG_METRIC, 1); write_reg(CFG_SUBQ, 4); write_reg(CFG_RCOUNT, 5);
        write_reg(CFG_LCOUNT, 300);
        run_phase(50, 300);
        write_reg(CFG_PAIR, 1); write_reg(CFG_SUBQ, 0); write_reg(CFG_RCOUNT, 0);
        write_reg(CFG_LCOUNT, 0);
        run_phase(25, 1);
        write_reg(CFG_METRIC, 0); write_reg(CFG_SUBQ, 15); write_reg(CFG_RCOUNT, 31);
        write_reg(CFG_LCOUNT, 131071);
        run_phase(50, 65535);
        $display("covered %0d scans and %0d readouts, %0d results checked",
                 n_scans, n_reads, board.checked);
        $display("settings: both metrics, both label forms, k 0..31, lists 0..131071");
        if (board.errors == 0 && board.q_rank.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule
